### design/assert_macros.svh
// assertion helpers for the rgb to hsv design, included by the top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every rising clock edge outside reset
`define RTHSV_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("rthsv assertion failed");

// implication checked at every rising clock edge outside reset
`define RTHSV_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("rthsv implication failed");

`endif

### design/rthsv_pkg.sv
// ----------------------------------------------------------------------------
// rthsv_pkg
// shared widths and the work record that travels down the divider chain
// ----------------------------------------------------------------------------
package rthsv_pkg;

  localparam int unsigned ChanW = 8;
  localparam int unsigned QuoW  = 16;
  // hue divisor is six times chroma, below 1536
  localparam int unsigned DenHW = 11;
  localparam int unsigned DenSW = ChanW;
  localparam int unsigned InDataW  = 3 * ChanW;
  localparam int unsigned OutDataW = 2 * QuoW + ChanW;

  typedef struct packed {
    logic [DenHW-1:0] rem_h;
    logic [DenHW-1:0] den_h;
    logic [DenSW-1:0] rem_s;
    logic [DenSW-1:0] den_s;
    logic [QuoW-1:0]  quo_h;
    logic [QuoW-1:0]  quo_s;
    logic             sat_full;
    logic [ChanW-1:0] val;
  } rthsv_work_t;

endpackage

### design/rthsv_front.sv
// ----------------------------------------------------------------------------
// rthsv_front
// first stage: max, min, chroma, hue numerator and both divisors
// ----------------------------------------------------------------------------
module rthsv_front import rthsv_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  output logic             ready_o,
  input  logic [ChanW-1:0] red_i,
  input  logic [ChanW-1:0] green_i,
  input  logic [ChanW-1:0] blue_i,
  output logic             valid_o,
  input  logic             ready_i,
  output rthsv_work_t      work_o
);

  logic             valid_q;
  rthsv_work_t      work_q, work_d;
  logic             red_max, green_max;
  logic [ChanW-1:0] max_v, min_v, chroma;
  logic [DenHW-1:0] c_ext, six_c, base, add_a, sub_b, num;

  always_comb begin
    red_max   = (red_i >= green_i) && (red_i >= blue_i);
    green_max = !red_max && (green_i >= blue_i);
    if (red_max) begin
      max_v = red_i;
    end else if (green_max) begin
      max_v = green_i;
    end else begin
      max_v = blue_i;
    end
    min_v = red_i;
    if (green_i < min_v) min_v = green_i;
    if (blue_i < min_v) min_v = blue_i;
    chroma = max_v - min_v;

    c_ext = DenHW'(chroma);
    six_c = DenHW'({c_ext, 2'b00}) + DenHW'({c_ext, 1'b0});
    // numerator stays in [0, 6c), so wrapping 11-bit arithmetic is exact
    if (red_max) begin
      base  = (green_i < blue_i) ? six_c : '0;
      add_a = DenHW'(green_i);
      sub_b = DenHW'(blue_i);
    end else if (green_max) begin
      base  = DenHW'({c_ext, 1'b0});
      add_a = DenHW'(blue_i);
      sub_b = DenHW'(red_i);
    end else begin
      base  = DenHW'({c_ext, 2'b00});
      add_a = DenHW'(red_i);
      sub_b = DenHW'(green_i);
    end
    num = base + add_a - sub_b;

    work_d          = '0;
    work_d.val      = max_v;
    work_d.sat_full = (max_v != '0) && (min_v == '0);
    // a zero remainder over an all-ones divisor yields a zero quotient
    if (chroma == '0) begin
      work_d.rem_h = '0;
      work_d.den_h = '1;
    end else begin
      work_d.rem_h = num;
      work_d.den_h = six_c;
    end
    if (max_v == '0 || min_v == '0) begin
      work_d.rem_s = '0;
      work_d.den_s = '1;
    end else begin
      work_d.rem_s = chroma;
      work_d.den_s = max_v;
    end
  end

  assign ready_o = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign work_o  = work_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      work_q <= work_d;
    end
  end

endmodule

### design/rthsv_cell.sv
// ----------------------------------------------------------------------------
// rthsv_cell
// one restoring-division step for hue and saturation, one quotient bit each
// ----------------------------------------------------------------------------
module rthsv_cell import rthsv_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  output logic        ready_o,
  input  rthsv_work_t work_i,
  output logic        valid_o,
  input  logic        ready_i,
  output rthsv_work_t work_o
);

  logic             valid_q;
  rthsv_work_t      work_q, work_d;
  logic [DenHW:0]   trial_h;
  logic [DenSW:0]   trial_s;
  logic             bit_h, bit_s;

  always_comb begin
    trial_h = {work_i.rem_h, 1'b0};
    trial_s = {work_i.rem_s, 1'b0};
    bit_h   = trial_h >= {1'b0, work_i.den_h};
    bit_s   = trial_s >= {1'b0, work_i.den_s};
    work_d  = work_i;
    work_d.rem_h = bit_h ? DenHW'(trial_h - {1'b0, work_i.den_h}) : trial_h[DenHW-1:0];
    work_d.rem_s = bit_s ? DenSW'(trial_s - {1'b0, work_i.den_s}) : trial_s[DenSW-1:0];
    work_d.quo_h = {work_i.quo_h[QuoW-2:0], bit_h};
    work_d.quo_s = {work_i.quo_s[QuoW-2:0], bit_s};
  end

  assign ready_o = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign work_o  = work_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      work_q <= work_d;
    end
  end

endmodule

### design/rgb_to_hsv_pixel.sv
// ----------------------------------------------------------------------------
// rgb_to_hsv_pixel
// converts 8-bit rgb pixels to 16-bit hue, 16-bit saturation, 8-bit value
// ----------------------------------------------------------------------------
// usage:
//   s_axis carries one pixel per beat: red, green, blue in tdata.
//   m_axis returns one beat per pixel, in order: hue, saturation, brightness.
//   from input beat to output beat a pixel passes one setup stage
//   (max, min, chroma, hue numerator) and a chain of 16 divider cells,
//   each producing one quotient bit of both divisions.
//   throughput is one pixel per cycle while m_axis_tready is high; every
//   stage has its own valid bit, so a stage that holds no beat takes a
//   new one even while the result at the end of the chain waits.
//   when m_axis_tready is low the finished beat holds in the last cell and
//   beats pile up behind it; s_axis_tready falls once all 17 stages are full.
//   reset clears all stage valid bits; no output beat is pending after it.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rgb_to_hsv_pixel import rthsv_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // red [7:0], green [15:8], blue [23:16]
  input  logic [InDataW-1:0]  s_axis_tdata,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // hue [15:0], saturation [31:16], brightness [39:32]
  output logic [OutDataW-1:0] m_axis_tdata
);

  logic        valid_c [QuoW+1];
  logic        ready_c [QuoW+1];
  rthsv_work_t work_c  [QuoW+1];
  rthsv_work_t last_w;
  logic [QuoW-1:0] sat;

  rthsv_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_axis_tvalid),
    .ready_o (s_axis_tready),
    .red_i   (s_axis_tdata[ChanW-1:0]),
    .green_i (s_axis_tdata[2*ChanW-1:ChanW]),
    .blue_i  (s_axis_tdata[3*ChanW-1:2*ChanW]),
    .valid_o (valid_c[0]),
    .ready_i (ready_c[0]),
    .work_o  (work_c[0])
  );

  for (genvar i = 0; i < QuoW; i++) begin : g_cell
    rthsv_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (valid_c[i]),
      .ready_o (ready_c[i]),
      .work_i  (work_c[i]),
      .valid_o (valid_c[i+1]),
      .ready_i (ready_c[i+1]),
      .work_o  (work_c[i+1])
    );
  end

  assign ready_c[QuoW] = m_axis_tready;
  assign last_w        = work_c[QuoW];
  // quotient would be 65536 when the smallest channel is zero
  assign sat           = last_w.sat_full ? '1 : last_w.quo_s;
  assign m_axis_tvalid = valid_c[QuoW];
  assign m_axis_tdata  = {last_w.val, sat, last_w.quo_h};

  `RTHSV_ASSERT_IMPL(a_black_zero,
    m_axis_tvalid && (m_axis_tdata[39:32] == 8'd0),
    (m_axis_tdata[31:16] == 16'd0) && (m_axis_tdata[15:0] == 16'd0))
  `RTHSV_ASSERT_IMPL(a_gray_hue,
    m_axis_tvalid && (m_axis_tdata[31:16] == 16'd0),
    m_axis_tdata[15:0] == 16'd0)
  `RTHSV_ASSERT(a_chain_ready,
    (m_axis_tready || !m_axis_tvalid) -> s_axis_tready)

endmodule

### dv/tb_rgb_to_hsv_pixel.sv
// ----------------------------------------------------------------------------
// tb_rgb_to_hsv_pixel
// drives rgb pixels into the converter and checks every hsv beat against
// a predictor in this file; corner pixels first, then random pixels under
// random idling, with no idling, and under long output stalls
// ----------------------------------------------------------------------------
module tb_rgb_to_hsv_pixel import rthsv_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned IdlePct   = 34;
  localparam int unsigned TailWait  = 60;
  localparam int unsigned StallLim  = 1000;

  // packed from the top bit down: brightness, saturation, hue
  typedef struct packed {
    logic [ChanW-1:0] val;
    logic [QuoW-1:0]  sat;
    logic [QuoW-1:0]  hue;
  } hsv_t;

  typedef struct {
    logic [ChanW-1:0] red;
    logic [ChanW-1:0] green;
    logic [ChanW-1:0] blue;
    hsv_t             hsv;
  } pending_pixel_t;

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata  = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;

  pending_pixel_t pending_hsv_q[$];
  int unsigned    fail_count   = 0;
  int unsigned    quiet_cycles = 0;
  int unsigned    hold_left    = 0;
  bit             in_idle_on   = 1'b1;
  bit             out_idle_on  = 1'b1;
  bit             long_holds   = 1'b0;

  rgb_to_hsv_pixel u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #2 clk_i = ~clk_i;

  function automatic hsv_t predict_hsv(logic [ChanW-1:0] r, logic [ChanW-1:0] g,
                                       logic [ChanW-1:0] b);
    hsv_t res;
    int   hi;
    int   lo;
    int   chroma;
    int   num;
    int   quo;
    hi = (r > g) ? int'(r) : int'(g);
    hi = (hi > int'(b)) ? hi : int'(b);
    lo = (r < g) ? int'(r) : int'(g);
    lo = (lo < int'(b)) ? lo : int'(b);
    chroma = hi - lo;
    res.val = hi[ChanW-1:0];
    res.sat = '0;
    res.hue = '0;
    if (hi != 0) begin
      quo = (chroma << 16) / hi;
      res.sat = (quo > 65535) ? 16'hFFFF : quo[QuoW-1:0];
    end
    if (chroma != 0) begin
      // red wins ties, then green
      if (hi == int'(r)) begin
        num = int'(g) - int'(b);
        if (num < 0) num += 6 * chroma;
      end else if (hi == int'(g)) begin
        num = int'(b) - int'(r) + 2 * chroma;
      end else begin
        num = int'(r) - int'(g) + 4 * chroma;
      end
      if (num < 0) num = 0;
      quo = (num * 65536) / (6 * chroma);
      res.hue = (quo > 65535) ? 16'hFFFF : quo[QuoW-1:0];
    end
    return res;
  endfunction

  task automatic report_mismatch(input string what);
    $display("mismatch at %0t: %s", $realtime, what);
    fail_count++;
  endtask

  task automatic send_pixel(input logic [ChanW-1:0] r, input logic [ChanW-1:0] g,
                            input logic [ChanW-1:0] b);
    pending_pixel_t pend;
    while (in_idle_on && $urandom_range(99) < IdlePct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {b, g, r};
    do @(posedge clk_i); while (!s_axis_tready);
    pend.red   = r;
    pend.green = g;
    pend.blue  = b;
    pend.hsv   = predict_hsv(r, g, b);
    pending_hsv_q.push_back(pend);
  endtask

  task automatic send_random_pixels(input int unsigned count);
    logic [ChanW-1:0] px[3];
    int unsigned      sel;
    repeat (count) begin
      px[0] = ChanW'($urandom);
      px[1] = ChanW'($urandom);
      px[2] = ChanW'($urandom);
      sel = $urandom_range(2);
      case ($urandom_range(9))
        0: begin
          px[1] = px[0];
          px[2] = px[0];
        end
        1: px[sel] = '0;
        2: px[sel] = '1;
        // two channels equal, so the tie order of the hue cases matters
        3: px[(sel + 1) % 3] = px[sel];
        default: ;
      endcase
      send_pixel(px[0], px[1], px[2]);
    end
  endtask

  task automatic test_corner_pixels();
    send_pixel(8'd0,   8'd0,   8'd0);
    send_pixel(8'd255, 8'd255, 8'd255);
    send_pixel(8'd128, 8'd128, 8'd128);
    send_pixel(8'd1,   8'd1,   8'd1);
    send_pixel(8'd255, 8'd0,   8'd0);
    send_pixel(8'd0,   8'd255, 8'd0);
    send_pixel(8'd0,   8'd0,   8'd255);
    send_pixel(8'd1,   8'd0,   8'd0);
    send_pixel(8'd0,   8'd1,   8'd0);
    send_pixel(8'd0,   8'd0,   8'd1);
    // red largest with green below blue wraps the hue
    send_pixel(8'd255, 8'd0,   8'd1);
    send_pixel(8'd200, 8'd10,  8'd200);
    send_pixel(8'd255, 8'd255, 8'd0);
    send_pixel(8'd10,  8'd200, 8'd200);
    send_pixel(8'd255, 8'd0,   8'd255);
    send_pixel(8'd0,   8'd255, 8'd255);
    send_pixel(8'd255, 8'd254, 8'd254);
    send_pixel(8'd254, 8'd255, 8'd254);
    send_pixel(8'd254, 8'd254, 8'd255);
    send_pixel(8'd128, 8'd64,  8'd32);
    send_pixel(8'd17,  8'd99,  8'd200);
    send_pixel(8'd170, 8'd85,  8'd255);
  endtask

  task automatic test_random_idling(input int unsigned count);
    in_idle_on  = 1'b1;
    out_idle_on = 1'b1;
    long_holds  = 1'b0;
    send_random_pixels(count);
  endtask

  task automatic test_full_rate(input int unsigned count);
    in_idle_on  = 1'b0;
    out_idle_on = 1'b0;
    long_holds  = 1'b0;
    send_random_pixels(count);
  endtask

  // long output stalls fill the whole pipeline and stop the input side
  task automatic test_output_stalls(input int unsigned count);
    in_idle_on  = 1'b0;
    out_idle_on = 1'b1;
    long_holds  = 1'b1;
    send_random_pixels(count);
  endtask

  always @(posedge clk_i) begin
    if (hold_left != 0) begin
      m_axis_tready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (long_holds && $urandom_range(99) < 2) begin
      m_axis_tready <= 1'b0;
      hold_left <= $urandom_range(40, 20);
    end else begin
      m_axis_tready <= !(out_idle_on && $urandom_range(99) < IdlePct);
    end
  end

  always @(posedge clk_i) begin
    pending_pixel_t pend;
    hsv_t           got;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata;
      if (pending_hsv_q.size() == 0) begin
        report_mismatch($sformatf("beat with nothing expected, data %h", m_axis_tdata));
      end else begin
        pend = pending_hsv_q.pop_front();
        if (got.hue !== pend.hsv.hue)
          report_mismatch($sformatf("rgb %0d,%0d,%0d hue %0d want %0d", pend.red,
                                    pend.green, pend.blue, got.hue, pend.hsv.hue));
        if (got.sat !== pend.hsv.sat)
          report_mismatch($sformatf("rgb %0d,%0d,%0d saturation %0d want %0d", pend.red,
                                    pend.green, pend.blue, got.sat, pend.hsv.sat));
        if (got.val !== pend.hsv.val)
          report_mismatch($sformatf("rgb %0d,%0d,%0d brightness %0d want %0d", pend.red,
                                    pend.green, pend.blue, got.val, pend.hsv.val));
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= StallLim) begin
      $display("FAIL rgb_to_hsv_pixel");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_corner_pixels();
    test_random_idling(900);
    test_full_rate(450);
    test_output_stalls(450);
    s_axis_tvalid <= 1'b0;
    while (pending_hsv_q.size() != 0) @(posedge clk_i);
    repeat (TailWait) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("PASS rgb_to_hsv_pixel");
    end else begin
      $display("FAIL rgb_to_hsv_pixel");
    end
    $finish;
  end

endmodule
